@@ rtl/core/ofb_pkg.sv @@
// Package for the page-organized OLED frame buffer: item, command and result
// types, state encoding, geometry constants and display command bytes.
// No dependencies.
package ofb_pkg;

    // Display geometry. Each page holds COLUMNS bytes, and each byte covers
    // eight pixel rows.
    localparam int COLUMNS = 64;
    localparam int PAGES   = 6;

    // The store is kept as 64-bit words of eight column bytes each.
    localparam int GROUPS   = (COLUMNS + 7) / 8;
    localparam int WORDS    = PAGES * GROUPS;
    localparam int ADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int GRP_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int WORD_W   = 64;

    // Queue sizes.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // Display command bytes sent ahead of each page of data.
    localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h12;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_DRAW    = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_REFRESH = 2'd2
    } t_ofb_op;

    // Work kinds handed from the front end to the back end.
    typedef enum logic [1:0] {
        KIND_DRAW,
        KIND_CLEAR,
        KIND_REFRESH
    } t_ofb_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_CMD_PAGE,
        ST_CMD_LOW,
        ST_CMD_HIGH,
        ST_DATA
    } t_ofb_state;

    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] column;
        logic [5:0] row;
        logic       pixel_on;
        logic [2:0] page;
    } t_ofb_item;

    typedef struct packed {
        logic              is_data;
        logic [WORD_W-1:0] payload;
        logic              last_of_page;
    } t_ofb_result;

    typedef struct packed {
        t_ofb_kind         kind;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        lane;
        logic [2:0]        bit_sel;
        logic              pixel_on;
        logic [2:0]        page;
    } t_ofb_cmd;

endpackage

@@ rtl/core/oled_page_framebuffer.sv @@
// Page-organized monochrome OLED frame buffer, top level.
// Depends on ofb_pkg, ofb_front, ofb_cmd_fifo and ofb_back.
//
// This block keeps a COLUMNS by (8 * PAGES) pixel image, organized as pages of
// column bytes in the way page-mode OLED controllers expect, and streams one
// page at a time as controller items. Input items come in through a queue
// style port (push/full) and results leave through one (empty/pop). A draw
// item sets or clears one pixel; points off the panel are ignored. A clear
// item blanks the whole image at once and emits nothing. A refresh item
// emits three command items (page address 0xB0 plus the page, column low
// 0x00, column high 0x12), then the page's bytes as 64-bit data items, eight
// columns each with the lowest column in the lowest byte; last_of_page marks
// the final one. is_data selects between the command control byte (0x00) and
// the data control byte (0x40) on the bus. Refreshes of pages beyond the panel
// and unused operation codes are dropped. The front end takes one item every
// cycle while its two-entry command queue has room. In the back end a refresh
// picks up the command, emits three command items, then makes eight reads,
// one per cycle while the result queue has room, through the single read port
// of the frame store; a draw picks up, reads and writes back, and a clear only
// picks up. Result items leave through a four-entry queue, so a slow consumer
// stalls the refresh only once that queue fills. The store is held as 64-bit
// words with one valid bit each, so reset and clear take effect at once and
// no clearing pass is needed after reset.
module oled_page_framebuffer
    import ofb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_ofb_item   i_item,
    output logic        empty,
    input  logic        pop,
    output t_ofb_result o_result
);

    logic     cmdq_push;
    logic     cmdq_full;
    logic     cmdq_pop;
    logic     cmdq_empty;
    t_ofb_cmd front_cmd;
    t_ofb_cmd back_cmd;

    // The front end filters and classifies each item as it arrives.
    ofb_front u_front (
        .i_push      (push),
        .i_item      (i_item),
        .i_cmdq_full (cmdq_full),
        .o_full      (full),
        .o_cmd_push  (cmdq_push),
        .o_cmd       (front_cmd)
    );

    // The command queue lets the front end keep taking items while the back
    // end is busy with a refresh.
    ofb_cmd_fifo u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmdq_push),
        .i_cmd   (front_cmd),
        .o_full  (cmdq_full),
        .i_pop   (cmdq_pop),
        .o_empty (cmdq_empty),
        .o_cmd   (back_cmd)
    );

    // The back end owns the frame store and produces the result items.
    ofb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmdq_empty (cmdq_empty),
        .i_cmd        (back_cmd),
        .o_cmdq_pop   (cmdq_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_result     (o_result)
    );

endmodule

@@ rtl/core/ofb_front.sv @@
// Front end of the frame buffer: checks and classifies input items and turns
// them into work commands for the back end. Depends on ofb_pkg.
module ofb_front
    import ofb_pkg::*;
(
    input  logic      i_push,
    input  t_ofb_item i_item,
    input  logic      i_cmdq_full,
    output logic      o_full,
    output logic      o_cmd_push,
    output t_ofb_cmd  o_cmd
);

    logic cmd_ok;

    always_comb begin
        cmd_ok         = 1'b0;
        o_cmd          = '0;
        o_cmd.kind     = KIND_DRAW;
        o_cmd.lane     = i_item.column[2:0];
        o_cmd.bit_sel  = i_item.row[2:0];
        o_cmd.pixel_on = i_item.pixel_on;
        case (i_item.operation)
            OP_DRAW: begin
                // Points off the panel are dropped here.
                if (({2'b00, i_item.column} < 8'(COLUMNS)) &&
                    ({1'b0, i_item.row[5:3]} < 4'(PAGES))) begin
                    cmd_ok     = 1'b1;
                    o_cmd.kind = KIND_DRAW;
                    o_cmd.addr = ADDR_W'(i_item.row[5:3]) * ADDR_W'(GROUPS)
                               + ADDR_W'(i_item.column[5:3]);
                end
            end
            OP_CLEAR: begin
                cmd_ok     = 1'b1;
                o_cmd.kind = KIND_CLEAR;
            end
            OP_REFRESH: begin
                if ({1'b0, i_item.page} < 4'(PAGES)) begin
                    cmd_ok     = 1'b1;
                    o_cmd.kind = KIND_REFRESH;
                    o_cmd.page = i_item.page;
                    o_cmd.addr = ADDR_W'(i_item.page) * ADDR_W'(GROUPS);
                end
            end
            default: begin
                cmd_ok = 1'b0;
            end
        endcase
    end

    assign o_full     = i_cmdq_full;
    assign o_cmd_push = i_push && !i_cmdq_full && cmd_ok;

endmodule

@@ rtl/core/ofb_cmd_fifo.sv @@
// Short command queue between the front end and the back end of the frame
// buffer. Depends on ofb_pkg.
module ofb_cmd_fifo
    import ofb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_ofb_cmd i_cmd,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_empty,
    output t_ofb_cmd o_cmd
);

    t_ofb_cmd              r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ rtl/core/ofb_back.sv @@
// Back end of the frame buffer: the frame store memory with per-word valid
// bits, the draw/clear/refresh sequencer and the result queue.
// Depends on ofb_pkg.
module ofb_back
    import ofb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmdq_empty,
    input  t_ofb_cmd    i_cmd,
    output logic        o_cmdq_pop,
    output logic        o_empty,
    input  logic        i_pop,
    output t_ofb_result o_result
);

    // Frame store and its read port.
    logic [WORD_W-1:0] r_mem [WORDS];
    logic [WORD_W-1:0] r_rd_data;
    logic              r_rd_valid;
    logic [WORDS-1:0]  r_valid;
    logic [WORDS-1:0]  n_valid;

    // Sequencer.
    t_ofb_state        r_state;
    t_ofb_state        n_state;
    t_ofb_cmd          r_cmd;
    logic [GRP_W-1:0]  r_grp;
    logic [GRP_W-1:0]  n_grp;
    logic              r_pend;
    logic              n_pend;
    logic              r_pend_last;
    logic              n_pend_last;

    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              mem_we;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] old_word;
    logic              cmd_push;
    logic [7:0]        cmd_byte;

    // Result queue.
    t_ofb_result           r_q [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_head;
    logic [OUTQ_PTR_W-1:0] r_tail;
    logic [OUTQ_CNT_W-1:0] r_count;
    logic                  room;
    logic                  q_push;
    logic                  q_pop;
    t_ofb_result           q_item;

    assign room     = ({1'b0, r_count} + {{OUTQ_CNT_W{1'b0}}, r_pend})
                    < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);
    assign old_word = r_rd_valid ? r_rd_data : '0;

    always_comb begin
        n_state     = r_state;
        n_grp       = r_grp;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        n_valid     = r_valid;
        o_cmdq_pop  = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = r_cmd.addr;
        mem_we      = 1'b0;
        mem_wdata   = old_word;
        cmd_push    = 1'b0;
        cmd_byte    = CMD_COL_LOW;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmdq_empty) begin
                    o_cmdq_pop = 1'b1;
                    case (i_cmd.kind)
                        KIND_DRAW: begin
                            n_state = ST_DRAW_RD;
                        end
                        KIND_CLEAR: begin
                            // Dropping every valid bit makes each word read as zero.
                            n_valid = '0;
                        end
                        KIND_REFRESH: begin
                            n_state = ST_CMD_PAGE;
                            n_grp   = '0;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DRAW_RD: begin
                mem_re  = 1'b1;
                n_state = ST_DRAW_WR;
            end
            ST_DRAW_WR: begin
                mem_we = 1'b1;
                mem_wdata[{r_cmd.lane, r_cmd.bit_sel}] = r_cmd.pixel_on;
                n_valid[r_cmd.addr] = 1'b1;
                n_state = ST_IDLE;
            end
            ST_CMD_PAGE: begin
                cmd_byte = CMD_PAGE_BASE + {5'd0, r_cmd.page};
                if (room) begin
                    cmd_push = 1'b1;
                    n_state  = ST_CMD_LOW;
                end
            end
            ST_CMD_LOW: begin
                cmd_byte = CMD_COL_LOW;
                if (room) begin
                    cmd_push = 1'b1;
                    n_state  = ST_CMD_HIGH;
                end
            end
            ST_CMD_HIGH: begin
                cmd_byte = CMD_COL_HIGH;
                if (room) begin
                    cmd_push = 1'b1;
                    n_state  = ST_DATA;
                end
            end
            ST_DATA: begin
                mem_raddr = r_cmd.addr + ADDR_W'(r_grp);
                if (room) begin
                    mem_re      = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_last = (r_grp == GRP_W'(GROUPS - 1));
                    if (r_grp == GRP_W'(GROUPS - 1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_grp = r_grp + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_pend  <= 1'b0;
            r_grp   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_pend  <= n_pend;
            r_grp   <= n_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_last <= n_pend_last;
        if (o_cmdq_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_cmd.addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data  <= r_mem[mem_raddr];
            r_rd_valid <= r_valid[mem_raddr];
        end
    end

    // Command results are pushed from the command states, data results in the
    // cycle after their read. The sequence never lets the two coincide.
    always_comb begin
        q_item              = '0;
        q_item.is_data      = r_pend;
        q_item.last_of_page = r_pend && r_pend_last;
        q_item.payload      = r_pend ? old_word : {{(WORD_W - 8){1'b0}}, cmd_byte};
    end

    assign q_push   = cmd_push || r_pend;
    assign o_empty  = (r_count == '0);
    assign q_pop    = i_pop && !o_empty;
    assign o_result = r_q[r_head];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (q_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (q_pop) begin
                r_head <= r_head + 1'b1;
            end
            if (q_push && !q_pop) begin
                r_count <= r_count + 1'b1;
            end else if (q_pop && !q_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q[r_tail] <= q_item;
        end
    end

endmodule
